FILE: hdl/wbps_pkg.sv
`default_nettype none

package wbps_pkg;

  localparam int BYTE_W     = 8;
  localparam int ADDR_W     = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int PAT_WORDS  = 4;
  localparam int CARE_W     = 32;
  localparam int LEN_CFG_W  = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_WORD_0   = 3'd0,
    CFG_PAT_WORD_1   = 3'd1,
    CFG_PAT_WORD_2   = 3'd2,
    CFG_PAT_WORD_3   = 3'd3,
    CFG_CARE_MASK    = 3'd4,
    CFG_PAT_LENGTH   = 3'd5,
    CFG_BASE_ADDRESS = 3'd6
  } cfg_idx_t;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [BYTE_W-1:0] byte_t;

endpackage

`default_nettype wire

FILE: hdl/wbps_if.sv
`default_nettype none

interface wbps_in_if import wbps_pkg::*;;
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_in_range;

  modport source (output valid, output data_byte, output last_in_range, input ready);
  modport sink (input valid, input data_byte, input last_in_range, output ready);
endinterface

interface wbps_out_if import wbps_pkg::*;;
  logic  valid;
  logic  ready;
  addr_t match_address;

  modport source (output valid, output match_address, input ready);
  modport sink (input valid, input match_address, output ready);
endinterface

`default_nettype wire

FILE: hdl/wbps_out_buf.sv
`default_nettype none

module wbps_out_buf
  import wbps_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  wire addr_t up_addr,
  wbps_out_if.source down
);

  logic  out_valid_r;
  addr_t out_addr_r;
  logic  sk_valid_r;
  addr_t sk_addr_r;
  logic  push;

  // ready is registered: no path from down.ready to up_ready
  assign up_ready = !sk_valid_r;
  assign push     = up_valid && !sk_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else if (!out_valid_r || down.ready) begin
      if (sk_valid_r) begin
        out_valid_r <= 1'b1;
        sk_valid_r  <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      sk_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || down.ready) begin
      if (sk_valid_r) begin
        out_addr_r <= sk_addr_r;
      end else if (push) begin
        out_addr_r <= up_addr;
      end
    end else if (push) begin
      sk_addr_r <= up_addr;
    end
  end

  assign down.valid         = out_valid_r;
  assign down.match_address = out_addr_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_skid_fills_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !down.ready && push) |=> sk_valid_r && out_valid_r)
    else $error("stalled transaction lost");

endmodule

`default_nettype wire

FILE: hdl/wildcard_byte_pattern_scanner.sv
// channel   direction  payload                          handshake
// in_chan   in         data_byte[7:0], last_in_range    valid / ready
// out_chan  out        match_address[31:0]              valid / ready
// cfg_*     in         cfg_index[2:0], cfg_wdata[63:0]  cfg_we, no wait
//
// one byte per cycle while in_chan.ready is high; the edge that takes a byte
// loads the window stage, and the aligned compare loads the output buffer from
// that stage; a match passes the window stage and the buffer's output register
// the output buffer holds two transactions; in_chan.ready is a registered flag
// of that buffer, so input stops the cycle after a stall fills its second entry
// rst_n is synchronous; it clears the counts, valid flags and config (length to 1)
`default_nettype none

module wildcard_byte_pattern_scanner
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN_LENGTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  wbps_in_if.sink                    in_chan,
  wbps_out_if.source                 out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int LEN_W    = $clog2(MAX_PATTERN_LENGTH + 1);
  localparam int WIN_BITS = BYTE_W * MAX_PATTERN_LENGTH;

  // configuration
  logic [CFG_DATA_W-1:0] pat_r [PAT_WORDS];
  logic [CARE_W-1:0]     care_r;
  logic [LEN_CFG_W-1:0]  len_r;
  addr_t                 base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < PAT_WORDS; w++) begin
        pat_r[w] <= '0;
      end
      care_r <= '0;
      len_r  <= LEN_CFG_W'(1);
      base_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PAT_WORD_0:   pat_r[0] <= cfg_wdata;
        CFG_PAT_WORD_1:   pat_r[1] <= cfg_wdata;
        CFG_PAT_WORD_2:   pat_r[2] <= cfg_wdata;
        CFG_PAT_WORD_3:   pat_r[3] <= cfg_wdata;
        CFG_CARE_MASK:    care_r   <= cfg_wdata[CARE_W-1:0];
        CFG_PAT_LENGTH:   len_r    <= cfg_wdata[LEN_CFG_W-1:0];
        CFG_BASE_ADDRESS: base_r   <= cfg_wdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [PAT_WORDS*CFG_DATA_W-1:0] pat_flat;
  logic [LEN_W-1:0]                eff_len;
  logic [MAX_PATTERN_LENGTH-1:0]   in_use;
  logic [MAX_PATTERN_LENGTH-1:0]   care_use;
  logic                            has_fixed;

  always_comb begin
    for (int w = 0; w < PAT_WORDS; w++) begin
      pat_flat[w*CFG_DATA_W +: CFG_DATA_W] = pat_r[w];
    end
  end

  always_comb begin
    priority if (len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_r > LEN_CFG_W'(MAX_PATTERN_LENGTH)) begin
      eff_len = LEN_W'(MAX_PATTERN_LENGTH);
    end else begin
      eff_len = len_r[LEN_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PATTERN_LENGTH; i++) begin
      in_use[i] = (32'(eff_len) > 32'(i));
    end
  end

  assign care_use  = care_r[MAX_PATTERN_LENGTH-1:0] & in_use;
  assign has_fixed = |care_use;

  // window and range counters
  byte_t            win_r     [MAX_PATTERN_LENGTH];
  byte_t            win_shift [MAX_PATTERN_LENGTH];
  logic [LEN_W-1:0] fill_r;
  logic [LEN_W-1:0] fill_inc;
  addr_t            count_r;
  logic             in_acc;
  logic             buf_ready;

  assign in_chan.ready = buf_ready;
  assign in_acc        = in_chan.valid && buf_ready;

  always_comb begin
    win_shift[0] = in_chan.data_byte;
    for (int k = 1; k < MAX_PATTERN_LENGTH; k++) begin
      win_shift[k] = win_r[k-1];
    end
  end

  assign fill_inc = (fill_r == LEN_W'(MAX_PATTERN_LENGTH)) ? fill_r : fill_r + LEN_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      count_r <= '0;
    end else if (in_acc) begin
      if (in_chan.last_in_range) begin
        fill_r  <= '0;
        count_r <= '0;
      end else begin
        fill_r  <= fill_inc;
        count_r <= count_r + ADDR_W'(1);
      end
    end
  end

  // bytes older than the fill count are never compared, so no clear needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      win_r <= win_shift;
    end
  end

  // window stage
  logic  snap_valid_r;
  logic  snap_chk_r;
  addr_t snap_addr_r;
  byte_t snap_win_r [MAX_PATTERN_LENGTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (buf_ready) begin
      snap_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      snap_win_r  <= win_shift;
      snap_chk_r  <= has_fixed && (fill_inc >= eff_len);
      snap_addr_r <= base_r + count_r + ADDR_W'(1) - ADDR_W'(eff_len);
    end
  end

  // compare stage: reverse byte order, then shift so position 0 is the oldest byte
  logic [WIN_BITS-1:0]           rev_flat;
  logic [WIN_BITS-1:0]           aligned;
  logic [MAX_PATTERN_LENGTH-1:0] hit;
  logic                          snap_hit;

  always_comb begin
    for (int j = 0; j < MAX_PATTERN_LENGTH; j++) begin
      rev_flat[j*BYTE_W +: BYTE_W] = snap_win_r[MAX_PATTERN_LENGTH-1-j];
    end
  end

  assign aligned = rev_flat >> {LEN_W'(MAX_PATTERN_LENGTH) - eff_len, 3'b000};

  always_comb begin
    for (int i = 0; i < MAX_PATTERN_LENGTH; i++) begin
      hit[i] = !care_use[i] || (aligned[i*BYTE_W +: BYTE_W] == pat_flat[i*BYTE_W +: BYTE_W]);
    end
  end

  assign snap_hit = snap_valid_r && snap_chk_r && (&hit);

  wbps_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (snap_hit),
    .up_ready (buf_ready),
    .up_addr  (snap_addr_r),
    .down     (out_chan)
  );

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LEN_W'(MAX_PATTERN_LENGTH))
    else $error("fill count beyond window depth");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.last_in_range) |=> (fill_r == '0) && (count_r == '0))
    else $error("range state not cleared after last byte");

  a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_chan.last_in_range) |=> count_r == $past(count_r) + ADDR_W'(1))
    else $error("range byte count did not advance");

  a_hit_needs_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    snap_hit |-> has_fixed)
    else $error("match reported with no fixed position");

endmodule

`default_nettype wire
